FILE: rtl/core/bca_pkg.sv
// Shared types and constants for the bitmap chunk allocator.
// No dependencies; imported by every module of the block.
`default_nettype none
package bca_pkg;

    localparam int ADDR_W    = 32;
    localparam int CS_W      = 17;
    localparam int POOL_W    = 11;
    localparam int CNT_W     = 7;
    localparam int USED_W    = 11;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = 5;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_OOM  = 2'd1;
    localparam t_status ST_BAD  = 2'd2;
    localparam t_status ST_ZERO = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL = 2'd2;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic    load;        // capture request
        logic    check;       // register pool span
        logic    scan_init;   // clear scan counters
        logic    scan_step;   // examine one frame
        logic    mul;         // start frame times chunk size
        logic    div_addr;    // start offset / chunk size
        logic    free_setup;  // latch frame and clipped count
        logic    pos_setup;   // step frame down by one map word
        logic    mark_step;   // set one map bit, step back
        logic    clear_step;  // clear one map bit, step forward
        logic    fin;         // load output register
        t_status fin_code;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic zero;       // count is zero
        logic is_free;    // request is a free
        logic alloc_ok;   // allocate passes the count checks
        logic hit;        // run of free frames complete
        logic scan_end;   // last frame of the pool
        logic div_done;   // divider result ready
        logic bad;        // address fails range or alignment
        logic pos_done;   // word and bit position found
        logic last;       // final bit of mark or clear
    } t_sts;

endpackage
`default_nettype wire

FILE: rtl/core/bca_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on bca_pkg.
`default_nettype none
module bca_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [bca_pkg::ADDR_W-1:0] i_dividend,
    input  wire logic [bca_pkg::CS_W-1:0]   i_divisor,
    output logic                           o_done,
    output logic [bca_pkg::ADDR_W-1:0]     o_quo,
    output logic [bca_pkg::CS_W-1:0]       o_rem
);
    import bca_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [ADDR_W-1:0]    r_quo;
    logic [CS_W-1:0]      r_rem;
    logic [CS_W-1:0]      r_dsr;
    logic [CS_W:0]        rem_sh;
    logic                 take;

    // trial subtract of the shifted remainder
    assign rem_sh = {r_rem, r_quo[ADDR_W-1]};
    assign take   = rem_sh >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[ADDR_W-2:0], take};
            r_rem <= take ? CS_W'(rem_sh - {1'b0, r_dsr}) : rem_sh[CS_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

FILE: rtl/core/bca_dp.sv
// Datapath: configuration, used map, scan counters, divider, result register.
// Depends on bca_pkg and bca_div.
`default_nettype none
module bca_dp #(
    parameter int NUM_CHUNKS    = 1024,
    parameter int MAX_RUN       = 64,
    parameter int MAP_WORD_BITS = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [bca_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bca_pkg::ADDR_W-1:0]  i_cfg_data,
    input  wire logic                        i_req_type,
    input  wire logic [bca_pkg::ADDR_W-1:0]  i_chunk_addr,
    input  wire logic [bca_pkg::CNT_W-1:0]   i_chunk_count,
    input  wire bca_pkg::t_cmd               i_cmd,
    output bca_pkg::t_sts                    o_sts,
    output bca_pkg::t_status                 o_status,
    output logic [bca_pkg::ADDR_W-1:0]       o_result_addr,
    output logic [bca_pkg::USED_W-1:0]       o_used_count
);
    import bca_pkg::*;

    localparam int FW        = $clog2(NUM_CHUNKS + 1);
    localparam int MAP_WORDS = (NUM_CHUNKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WIW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIW       = $clog2(MAP_WORD_BITS);
    localparam int SPW       = FW + CS_W;
    localparam int CW        = (SPW > ADDR_W) ? SPW : ADDR_W;

    // configuration
    logic [ADDR_W-1:0] r_base;
    logic [CS_W-1:0]   r_csize;
    logic [POOL_W-1:0] r_pool_cfg;

    // request and working state
    logic                  r_req;
    logic [CNT_W-1:0]      r_cnt;
    logic [ADDR_W-1:0]     r_off;
    logic [SPW-1:0]        r_span;
    logic [SPW-1:0]        r_prod;
    logic [FW-1:0]         r_frame;
    logic [FW-1:0]         r_start;
    logic [WIW-1:0]        r_wi;
    logic [BIW-1:0]        r_bi;
    logic [CNT_W-1:0]      r_run;
    logic [CNT_W-1:0]      r_left;
    logic [CNT_W-1:0]      r_n;
    logic [USED_W-1:0]     r_used;
    logic [MAP_WORD_BITS-1:0] r_map [MAP_WORDS];

    logic [FW-1:0]     pool;
    logic [CS_W-1:0]   cs;
    logic              cur_bit;
    logic [CNT_W-1:0]  run_n;
    logic [FW-1:0]     rest;
    logic [CNT_W-1:0]  n_clip;
    logic [CNT_W-1:0]  n_free;
    logic [FW-1:0]     quo_frame;
    logic [31:0]       avail;
    logic [USED_W-1:0] used_next;
    logic              div_start;
    logic              div_done;
    logic [ADDR_W-1:0] div_q;
    logic [CS_W-1:0]   div_r;

    // effective pool size and chunk size
    assign pool = (32'(r_pool_cfg) > NUM_CHUNKS) ? FW'(NUM_CHUNKS) : FW'(r_pool_cfg);
    assign cs   = (r_csize == '0) ? CS_W'(1) : r_csize;
    assign avail = (32'(pool) > 32'(r_used)) ? 32'(pool) - 32'(r_used) : 32'd0;

    // scan of one frame
    assign cur_bit = r_map[r_wi][r_bi];
    assign run_n   = cur_bit ? '0 : r_run + 1'b1;

    // clipped free count
    assign quo_frame = FW'(div_q);
    assign rest      = pool - quo_frame;
    assign n_clip    = (32'(r_cnt) > MAX_RUN) ? CNT_W'(MAX_RUN) : r_cnt;
    assign n_free    = (32'(n_clip) > 32'(rest)) ? CNT_W'(rest) : n_clip;

    // used count after the current request
    always_comb begin
        used_next = r_used;
        if (i_cmd.fin_code == ST_OK) begin
            if (r_req == REQ_FREE) begin
                used_next = (r_used > USED_W'(r_n)) ? r_used - USED_W'(r_n) : '0;
            end else begin
                used_next = r_used + USED_W'(r_cnt);
            end
        end
    end

    // divider for offset / chunk size
    assign div_start = i_cmd.div_addr;

    bca_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_off),
        .i_divisor  (cs),
        .o_done     (div_done),
        .o_quo      (div_q),
        .o_rem      (div_r)
    );

    // status to controller
    always_comb begin
        o_sts.zero     = (r_cnt == '0);
        o_sts.is_free  = (r_req == REQ_FREE);
        o_sts.alloc_ok = (32'(r_cnt) <= MAX_RUN) && (32'(r_cnt) <= avail)
                         && (32'(r_cnt) <= 32'(pool));
        o_sts.hit      = (run_n == r_cnt);
        o_sts.scan_end = (32'(r_frame) + 32'd1 == 32'(pool));
        o_sts.div_done = div_done;
        o_sts.bad      = (CW'(r_off) >= CW'(r_span)) || (div_r != '0);
        o_sts.pos_done = (32'(r_frame) < MAP_WORD_BITS);
        o_sts.last     = (r_left == CNT_W'(1));
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= '0;
            r_csize    <= CS_W'(4096);
            r_pool_cfg <= POOL_W'(1024);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BASE: r_base     <= i_cfg_data;
                CFG_SIZE: r_csize    <= i_cfg_data[CS_W-1:0];
                CFG_POOL: r_pool_cfg <= i_cfg_data[POOL_W-1:0];
                default:  ;
            endcase
        end
    end

    // used map and used count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < MAP_WORDS; w++) begin
                r_map[w] <= '0;
            end
            r_used <= '0;
        end else begin
            if (i_cmd.mark_step) begin
                r_map[r_wi][r_bi] <= 1'b1;
            end else if (i_cmd.clear_step) begin
                r_map[r_wi][r_bi] <= 1'b0;
            end
            if (i_cmd.fin) begin
                r_used <= used_next;
            end
        end
    end

    // request capture, counters and arithmetic
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req_type;
            r_cnt <= i_chunk_count;
            r_off <= i_chunk_addr - r_base;
        end
        if (i_cmd.check) begin
            r_span <= SPW'(pool) * SPW'(cs);
        end
        if (i_cmd.mul) begin
            r_prod <= SPW'(r_start) * SPW'(cs);
        end
        if (i_cmd.scan_init) begin
            r_frame <= '0;
            r_wi    <= '0;
            r_bi    <= '0;
            r_run   <= '0;
        end else if (i_cmd.scan_step) begin
            r_run <= run_n;
            if (run_n == r_cnt) begin
                r_start <= r_frame + FW'(1) - FW'(r_cnt);
                r_left  <= r_cnt;
            end else begin
                r_frame <= r_frame + 1'b1;
                if (r_bi == BIW'(MAP_WORD_BITS - 1)) begin
                    r_bi <= '0;
                    r_wi <= r_wi + 1'b1;
                end else begin
                    r_bi <= r_bi + 1'b1;
                end
            end
        end else if (i_cmd.free_setup) begin
            r_frame <= quo_frame;
            r_wi    <= '0;
            r_left  <= n_free;
            r_n     <= n_free;
        end else if (i_cmd.pos_setup) begin
            // compare and subtract one map word per cycle
            if (32'(r_frame) >= MAP_WORD_BITS) begin
                r_frame <= r_frame - FW'(MAP_WORD_BITS);
                r_wi    <= r_wi + 1'b1;
            end else begin
                r_bi <= BIW'(r_frame);
            end
        end else if (i_cmd.mark_step) begin
            // walk back from the end of the run
            r_left <= r_left - 1'b1;
            if (r_bi == '0) begin
                r_bi <= BIW'(MAP_WORD_BITS - 1);
                r_wi <= r_wi - 1'b1;
            end else begin
                r_bi <= r_bi - 1'b1;
            end
        end else if (i_cmd.clear_step) begin
            r_left <= r_left - 1'b1;
            if (r_bi == BIW'(MAP_WORD_BITS - 1)) begin
                r_bi <= '0;
                r_wi <= r_wi + 1'b1;
            end else begin
                r_bi <= r_bi + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            o_status     <= i_cmd.fin_code;
            o_used_count <= used_next;
            if (i_cmd.fin_code == ST_OK && r_req == REQ_ALLOC) begin
                o_result_addr <= r_base + ADDR_W'(r_prod);
            end else begin
                o_result_addr <= '0;
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/bca_ctrl.sv
// Controller state machine: sequences check, scan, divide, mark and clear.
// Depends on bca_pkg.
`default_nettype none
module bca_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    input  wire bca_pkg::t_sts i_sts,
    output bca_pkg::t_cmd      o_cmd
);
    import bca_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_MARK  = 4'd4;
    localparam logic [3:0] S_DIV1  = 4'd5;
    localparam logic [3:0] S_POS   = 4'd6;
    localparam logic [3:0] S_CLEAR = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    logic [3:0] r_state, n_state;
    t_status    r_code, n_code;
    logic       r_out_valid, n_out_valid;
    logic       slot_free;

    assign slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_code      = r_code;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_cmd.fin_code = r_code;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check     = 1'b1;
                o_cmd.scan_init = 1'b1;
                if (i_sts.zero) begin
                    n_code  = ST_ZERO;
                    n_state = S_FIN;
                end else if (i_sts.is_free) begin
                    o_cmd.div_addr = 1'b1;
                    n_state        = S_DIV1;
                end else if (i_sts.alloc_ok) begin
                    n_state = S_SCAN;
                end else begin
                    n_code  = ST_OOM;
                    n_state = S_FIN;
                end
            end
            // one frame per cycle, first fit
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.hit) begin
                    n_state = S_MUL;
                end else if (i_sts.scan_end) begin
                    n_code  = ST_OOM;
                    n_state = S_FIN;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_MARK;
            end
            S_MARK: begin
                o_cmd.mark_step = 1'b1;
                if (i_sts.last) begin
                    n_code  = ST_OK;
                    n_state = S_FIN;
                end
            end
            S_DIV1: begin
                if (i_sts.div_done) begin
                    if (i_sts.bad) begin
                        n_code  = ST_BAD;
                        n_state = S_FIN;
                    end else begin
                        o_cmd.free_setup = 1'b1;
                        n_state          = S_POS;
                    end
                end
            end
            // word and bit of the first frame to clear
            S_POS: begin
                o_cmd.pos_setup = 1'b1;
                if (i_sts.pos_done) begin
                    n_state = S_CLEAR;
                end
            end
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.last) begin
                    n_code  = ST_OK;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (slot_free) begin
                    o_cmd.fin   = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_code      <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_code      <= n_code;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

FILE: rtl/core/bitmap_chunk_allocator.sv
// Top level of the first-fit bitmap chunk allocator.
// Depends on bca_pkg, bca_ctrl, bca_dp (which holds bca_div).
//
//   channel  signals                                   direction
//   in       i_in_valid/o_in_stall, req, addr, count   request in
//   out      o_out_valid/i_out_stall, status, addr, used result out
//   cfg      i_cfg_we, i_cfg_index, i_cfg_data         register write
//
// Allocate: capture, check, a first-fit scan that visits one map bit per
// cycle, the multiply, then a mark of the run. Free: capture, check, the
// 32-step divider, a walk over the map words to locate the frame, then a
// clear of the run. Zero count or a failed count check finish after the
// check, a bad address after the divider. One request at a time.
// Synchronous reset clears the map and used count, resets the configuration.
// A result waits in the output register while the next request is taken.
`default_nettype none
module bitmap_chunk_allocator #(
    parameter int NUM_CHUNKS    = 1024,
    parameter int MAX_RUN       = 64,
    parameter int MAP_WORD_BITS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [bca_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bca_pkg::ADDR_W-1:0]    i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_req_type,
    input  wire logic [bca_pkg::ADDR_W-1:0]    i_chunk_addr,
    input  wire logic [bca_pkg::CNT_W-1:0]     i_chunk_count,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output bca_pkg::t_status                   o_status,
    output logic [bca_pkg::ADDR_W-1:0]         o_result_addr,
    output logic [bca_pkg::USED_W-1:0]         o_used_count
);
    import bca_pkg::*;

    t_cmd cmd;
    t_sts sts;

    bca_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bca_dp #(
        .NUM_CHUNKS    (NUM_CHUNKS),
        .MAX_RUN       (MAX_RUN),
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_req_type    (i_req_type),
        .i_chunk_addr  (i_chunk_addr),
        .i_chunk_count (i_chunk_count),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_status      (o_status),
        .o_result_addr (o_result_addr),
        .o_used_count  (o_used_count)
    );

endmodule
`default_nettype wire

FILE: sim/bitmap_chunk_allocator_tb.sv
// Testbench for bitmap_chunk_allocator: directed and random allocate/free traffic
// checked against a first-fit pool predictor kept in a small scoreboard class.
// Depends on bca_pkg and the bitmap_chunk_allocator RTL.
module bitmap_chunk_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bca_pkg::*;

    localparam int NUM_CHUNKS = 1024;
    localparam int MAX_RUN    = 64;
    localparam int IDLE_LIMIT = 40000;

    typedef struct packed {
        t_status     status;
        logic [31:0] addr;
        logic [10:0] used;
    } t_answer;

    // Pool predictor plus queue of expected answers
    class pool_scoreboard;
        bit          used_bits[NUM_CHUNKS];
        int unsigned used_chunks;
        logic [31:0] base_addr;
        logic [16:0] chunk_bytes;
        logic [10:0] pool_chunks;
        t_answer     pending[$];
        int          mismatches;

        function void clear();
            foreach (used_bits[i]) used_bits[i] = 0;
            used_chunks = 0;
            base_addr   = 0;
            chunk_bytes = 17'd4096;
            pool_chunks = 11'd1024;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            if (idx == CFG_BASE) base_addr = val;
            else if (idx == CFG_SIZE) chunk_bytes = val[16:0];
            else if (idx == CFG_POOL) pool_chunks = val[10:0];
        endfunction

        // Apply one accepted request and queue its answer
        function void note_request(logic req, logic [31:0] addr, logic [6:0] cnt);
            int unsigned pool, cs, avail, start, n, frame;
            logic [31:0] off;
            bit found, free_run;
            t_answer a;
            pool = (pool_chunks > NUM_CHUNKS) ? NUM_CHUNKS : pool_chunks;
            cs = (chunk_bytes == 0) ? 1 : chunk_bytes;
            a.status = ST_OK;
            a.addr = 0;
            found = 0;
            start = 0;
            if (cnt == 0) begin
                a.status = ST_ZERO;
            end else if (req == REQ_ALLOC) begin
                avail = (pool > used_chunks) ? pool - used_chunks : 0;
                if (cnt <= MAX_RUN && cnt <= avail && cnt <= pool) begin
                    for (int s = 0; s + cnt <= pool && !found; s++) begin
                        free_run = 1;
                        for (int k = 0; k < cnt && free_run; k++)
                            if (used_bits[s + k]) free_run = 0;
                        if (free_run) begin
                            found = 1;
                            start = s;
                        end
                    end
                end
                if (found) begin
                    for (int k = 0; k < cnt; k++) used_bits[start + k] = 1;
                    used_chunks = (used_chunks + cnt) & 11'h7FF;
                    a.addr = base_addr + 32'(longint'(start) * cs);
                end else begin
                    a.status = ST_OOM;
                end
            end else begin
                off = addr - base_addr;
                if (longint'(off) >= longint'(pool) * cs || off % cs != 0) begin
                    a.status = ST_BAD;
                end else begin
                    frame = off / cs;
                    n = (cnt > MAX_RUN) ? MAX_RUN : cnt;
                    if (n > pool - frame) n = pool - frame;
                    for (int k = 0; k < n; k++) used_bits[frame + k] = 0;
                    used_chunks = (used_chunks > n) ? used_chunks - n : 0;
                end
            end
            a.used = used_chunks[10:0];
            pending.push_back(a);
        endfunction

        function void check_answer(t_answer got);
            t_answer want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d addr %h used %0d",
                             got.status, got.addr, got.used);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status || got.addr !== want.addr
                || got.used !== want.used) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: exp %0d/%h/%0d got %0d/%h/%0d",
                             want.status, want.addr, want.used,
                             got.status, got.addr, got.used);
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_index = 0;
    logic [31:0] i_cfg_data = 0;
    logic        i_in_valid = 0;
    logic        i_req_type = 0;
    logic [31:0] i_chunk_addr = 0;
    logic [6:0]  i_chunk_count = 0;
    logic        i_out_stall = 0;
    logic        o_in_stall, o_out_valid;
    t_status     o_status;
    logic [31:0] o_result_addr;
    logic [10:0] o_used_count;

    pool_scoreboard sb = new();
    int  idle_cycles = 0;
    bit  long_hold = 0;

    bitmap_chunk_allocator dut (.*);

    always #5 i_clk = ~i_clk;

    // Input acceptance, output checking, watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_request(i_req_type, i_chunk_addr, i_chunk_count);
            if (o_out_valid && !i_out_stall)
                sb.check_answer({o_status, o_result_addr, o_used_count});
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Receiver: random stalls, with one long hold-off
    initial begin
        int w;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold) begin
                i_out_stall <= 1;
                repeat (3000) @(posedge i_clk);
                long_hold = 0;
            end
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (w != 0) begin
                i_out_stall <= 1;
                repeat (w) @(posedge i_clk);
            end
            i_out_stall <= 0;
            @(posedge i_clk iff o_out_valid);
        end
    end

    task automatic send(logic req, logic [31:0] addr, logic [6:0] cnt, int gap);
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1;
        i_req_type    <= req;
        i_chunk_addr  <= addr;
        i_chunk_count <= cnt;
        @(posedge i_clk iff !o_in_stall);
    endtask

    task automatic rand_gap(output int g);
        g = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
    endtask

    // Wait for idle, then write a register
    task automatic set_reg(logic [1:0] idx, logic [31:0] val);
        i_in_valid <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we    <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.write_reg(idx, val);
    endtask

    // Address of frame f in the current setting
    function automatic logic [31:0] frame_addr(int f);
        int unsigned cs;
        cs = (sb.chunk_bytes == 0) ? 1 : sb.chunk_bytes;
        return sb.base_addr + 32'(longint'(f) * cs);
    endfunction

    task automatic random_phase(int items, int max_cnt);
        int g, pool, f;
        logic [31:0] a;
        logic [6:0] c;
        pool = (sb.pool_chunks > NUM_CHUNKS) ? NUM_CHUNKS : sb.pool_chunks;
        for (int i = 0; i < items; i++) begin
            rand_gap(g);
            if (i % 100 > 80) g = 0;
            c = 7'($urandom_range(1, max_cnt));
            if ($urandom_range(0, 19) == 0) c = 7'($urandom_range(0, 127));
            if ($urandom_range(0, 1)) begin
                send(REQ_ALLOC, $urandom, c, g);
            end else begin
                f = (pool > 0) ? $urandom_range(0, pool - 1) : 0;
                a = frame_addr(f);
                case ($urandom_range(0, 9))
                    0: a = $urandom;
                    1: a = a + 1;
                    2: a = frame_addr(pool);
                    default: ;
                endcase
                send(REQ_FREE, a, c, g);
            end
        end
    endtask

    initial begin
        sb.clear();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: zero count, extremes, oversized requests, bad addresses
        send(REQ_ALLOC, 32'hFFFF_FFFF, 7'd0, 0);
        send(REQ_FREE, 32'h0, 7'd0, 0);
        send(REQ_ALLOC, 32'h0, 7'd64, 0);
        send(REQ_ALLOC, 32'h0, 7'd65, 0);
        send(REQ_ALLOC, 32'h0, 7'd127, 0);
        send(REQ_ALLOC, 32'h0, 7'd1, 2);
        send(REQ_FREE, 32'h0000_1000, 7'd1, 0);
        send(REQ_FREE, 32'h0000_0001, 7'd1, 0);
        send(REQ_FREE, 32'h0040_0000, 7'd1, 0);
        send(REQ_FREE, 32'hFFFF_F000, 7'd1, 0);
        send(REQ_FREE, 32'h003F_F000, 7'd127, 0);
        send(REQ_FREE, 32'h0, 7'd127, 0);
        send(REQ_FREE, 32'h0, 7'd5, 0);
        set_reg(CFG_POOL, 32'd0);
        send(REQ_ALLOC, 32'h0, 7'd1, 0);
        send(REQ_FREE, 32'h0, 7'd1, 0);
        set_reg(CFG_POOL, 32'h7FF);
        set_reg(CFG_SIZE, 32'd0);
        set_reg(CFG_BASE, 32'hFFFF_FFF0);
        send(REQ_ALLOC, 32'h0, 7'd40, 0);
        send(REQ_FREE, 32'hFFFF_FFF8, 7'd64, 0);
        set_reg(CFG_SIZE, 32'h1_0000);
        send(REQ_ALLOC, 32'h0, 7'd8, 0);
        send(REQ_FREE, 32'hFFFF_FFF0, 7'd64, 0);

        // Random phases over several settings; long hold in the first
        set_reg(CFG_POOL, 32'd40);
        set_reg(CFG_SIZE, 32'd64);
        set_reg(CFG_BASE, 32'h1000_0000);
        long_hold = 1;
        random_phase(250, 8);
        set_reg(CFG_POOL, 32'd1);
        set_reg(CFG_SIZE, 32'd1);
        set_reg(CFG_BASE, 32'h0);
        random_phase(80, 2);
        set_reg(CFG_POOL, 32'd200);
        set_reg(CFG_SIZE, 32'd3);
        set_reg(CFG_BASE, $urandom);
        random_phase(300, 20);
        set_reg(CFG_POOL, 32'd1024);
        set_reg(CFG_SIZE, 32'h1FFFF);
        set_reg(CFG_BASE, 32'hFFFF_FFFF);
        random_phase(60, 64);
        set_reg(CFG_POOL, 32'd96);
        set_reg(CFG_SIZE, 32'd4096);
        set_reg(CFG_BASE, 32'h8000_0000);
        random_phase(340, 12);
        i_in_valid <= 0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
